[src/bfpm_pkg.sv]
// bfpm_pkg: shared widths, codes and types for the best-fit pool matcher
// depends on nothing; imported by bfpm_cell, best_fit_pool_matcher and the bench
package bfpm_pkg;

  // pool depth, valid range 2 .. 127 so the fill count fits pool_fill
  localparam int POOL_DEPTH = 64;
  localparam int AMT_W = 31;
  localparam int TOTAL_W = 16;
  localparam int POOL_FILL_W = 7;
  localparam int FILL_CNT_W = $clog2(POOL_DEPTH + 1);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_REQUEST = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic ins;
    logic rem;
    logic clr;
  } bfpm_ctrl_t;

endpackage

[src/best_fit_pool_matcher.sv]
// best_fit_pool_matcher: top level, a row of bfpm_cell slots plus counters
// depends on bfpm_pkg and bfpm_cell
//
// Best-fit matcher over a pool of up to POOL_DEPTH capacities kept in
// ascending order in a chain of cells. Pulse start with mode and amount
// while busy is low; the item is taken at that edge and its single result
// appears on status, matched_value, match_total and pool_fill in the next
// cycle, marked by done for exactly one cycle. No item ever stalls the chain:
// each cell compares its own value with the broadcast amount and shifts
// with its neighbor in the same cycle, so a clear, an add or a request all
// finish at the accepting edge and busy never rises. The receiver cannot
// hold results off, so capture them while done is high. match_total and
// pool_fill hold their values between items. Adds into a full pool are
// dropped with status full; a request that nothing fits reports a miss
// with matched_value zero. Values never written are never read.
module best_fit_pool_matcher
  import bfpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             mode,
  input  logic [AMT_W-1:0]       amount,
  output logic                   done,
  output logic [1:0]             status,
  output logic [AMT_W-1:0]       matched_value,
  output logic [TOTAL_W-1:0]     match_total,
  output logic [POOL_FILL_W-1:0] pool_fill
);

  // cell chain
  logic [AMT_W-1:0]      val  [POOL_DEPTH];
  logic [AMT_W-1:0]      pick [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] occ;
  logic [POOL_DEPTH-1:0] le;
  logic [POOL_DEPTH-1:0] ge;

  bfpm_ctrl_t ctrl;

  logic                  accept;
  logic                  full;
  logic                  hit;
  logic [AMT_W-1:0]      hit_val;

  // counters and result registers
  logic [FILL_CNT_W-1:0] fill_cnt;
  logic [FILL_CNT_W-1:0] fill_cnt_next;
  logic [TOTAL_W-1:0]    match_cnt;
  logic [TOTAL_W-1:0]    match_cnt_next;
  logic [1:0]            status_next;
  logic [AMT_W-1:0]      matched_value_next;

  // the chain finishes any item at the accepting edge, so busy never rises
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // pool is a prefix of occupied cells, so the last cell tells full
  assign full = occ[POOL_DEPTH-1];
  assign hit  = |ge;

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      hit_val = hit_val | pick[i];
    end
  end

  // broadcast control
  always_comb begin
    ctrl.ins = 1'b0;
    ctrl.rem = 1'b0;
    ctrl.clr = 1'b0;
    if (accept) begin
      unique case (mode)
        MODE_CLEAR:   ctrl.clr = 1'b1;
        MODE_ADD:     ctrl.ins = !full;
        MODE_REQUEST: ctrl.rem = hit;
        default: begin
          // unused code: nothing changes
        end
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < POOL_DEPTH; g++) begin : g_cell
      // head of chain acts as an occupied cell below everything;
      // tail sees an empty cell beyond it
      bfpm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .amount   (amount),
        .prev_val ((g == 0) ? '0   : val[(g == 0) ? 0 : g - 1]),
        .prev_occ ((g == 0) ? 1'b1 : occ[(g == 0) ? 0 : g - 1]),
        .prev_le  ((g == 0) ? 1'b1 : le[(g == 0) ? 0 : g - 1]),
        .prev_ge  ((g == 0) ? 1'b0 : ge[(g == 0) ? 0 : g - 1]),
        .next_val ((g == POOL_DEPTH - 1) ? '0
                   : val[(g == POOL_DEPTH - 1) ? g : g + 1]),
        .next_occ ((g == POOL_DEPTH - 1) ? 1'b0
                   : occ[(g == POOL_DEPTH - 1) ? g : g + 1]),
        .val      (val[g]),
        .occ      (occ[g]),
        .le       (le[g]),
        .ge       (ge[g]),
        .pick     (pick[g])
      );
    end
  endgenerate

  // counters follow the chain operation
  always_comb begin
    fill_cnt_next  = fill_cnt;
    match_cnt_next = match_cnt;
    if (ctrl.clr) begin
      fill_cnt_next  = '0;
      match_cnt_next = '0;
    end else if (ctrl.ins) begin
      fill_cnt_next = fill_cnt + FILL_CNT_W'(1);
    end else if (ctrl.rem) begin
      fill_cnt_next = fill_cnt - FILL_CNT_W'(1);
      if (match_cnt != TOTAL_MAX) begin
        match_cnt_next = match_cnt + TOTAL_W'(1);
      end
    end
  end

  // result fields for the item at hand
  always_comb begin
    status_next        = STAT_OK;
    matched_value_next = '0;
    unique case (mode)
      MODE_ADD: begin
        if (full) begin
          status_next = STAT_FULL;
        end
      end
      MODE_REQUEST: begin
        if (hit) begin
          matched_value_next = hit_val;
        end else begin
          status_next = STAT_MISS;
        end
      end
      default: begin
        // clear and unused code report ok
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt  <= '0;
      match_cnt <= '0;
      done      <= 1'b0;
    end else begin
      fill_cnt  <= fill_cnt_next;
      match_cnt <= match_cnt_next;
      done      <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      matched_value <= matched_value_next;
    end
  end

  assign match_total = match_cnt;
  assign pool_fill   = POOL_FILL_W'(fill_cnt);

  // checks
  logic [POOL_DEPTH:0] occ_plus;
  logic                unordered;

  assign occ_plus = {1'b0, occ} + (POOL_DEPTH + 1)'(1);

  always_comb begin
    unordered = 1'b0;
    for (int i = 0; i < POOL_DEPTH - 1; i++) begin
      if (occ[i+1] && (val[i] > val[i+1])) begin
        unordered = 1'b1;
      end
    end
  end

  a_fill_matches_chain: assert property (@(posedge clk) disable iff (rst)
    $countones(occ) == fill_cnt)
    else $error("fill count disagrees with occupied cells");

  a_occ_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot(occ_plus))
    else $error("occupied cells are not packed at the head");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    !unordered)
    else $error("pool values out of order");

  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("no result after an accepted item");

  a_miss_keeps_pool: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_MISS)) |-> (fill_cnt == $past(fill_cnt)))
    else $error("a miss changed the pool");

endmodule

[src/bfpm_cell.sv]
// bfpm_cell: one slot of the sorted capacity chain
// holds one value and its occupied flag; trades values with both neighbors
// depends on bfpm_pkg
module bfpm_cell
  import bfpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  bfpm_ctrl_t       ctrl,
  input  logic [AMT_W-1:0] amount,
  input  logic [AMT_W-1:0] prev_val,
  input  logic             prev_occ,
  input  logic             prev_le,
  input  logic             prev_ge,
  input  logic [AMT_W-1:0] next_val,
  input  logic             next_occ,
  output logic [AMT_W-1:0] val,
  output logic             occ,
  output logic             le,
  output logic             ge,
  output logic [AMT_W-1:0] pick
);

  logic [AMT_W-1:0] val_next;
  logic             occ_next;

  assign le = occ && (val <= amount);
  assign ge = occ && (val >= amount);
  // first cell that fits offers its value for the match
  assign pick = (ge && !prev_ge) ? val : '0;

  always_comb begin
    val_next = val;
    occ_next = occ;
    if (ctrl.clr) begin
      occ_next = 1'b0;
    end else if (ctrl.ins) begin
      occ_next = prev_occ;
      if (!le) begin
        val_next = prev_le ? amount : prev_val;
      end
    end else if (ctrl.rem) begin
      occ_next = next_occ;
      if (ge || !occ) begin
        val_next = next_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

[dv/best_fit_pool_matcher_tb.sv]
// best_fit_pool_matcher_tb: self-checking bench for the best-fit pool matcher
// depends on bfpm_pkg and best_fit_pool_matcher; predicts every result with a
// sorted queue model and compares it field by field against the done strobe
`timescale 1ns / 100ps

module best_fit_pool_matcher_tb;
  import bfpm_pkg::*;

  // mode 3 has no operation behind it, the block must leave all state alone
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [AMT_W-1:0] AMT_MAX = '1;
  localparam int MAX_GAP = 18;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct {
    logic [1:0]       mode;
    logic [AMT_W-1:0] amount;
    int unsigned      gap;
  } pool_item_t;

  typedef struct {
    logic [1:0]             status;
    logic [AMT_W-1:0]       matched;
    logic [TOTAL_W-1:0]     total;
    logic [POOL_FILL_W-1:0] fill;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] mode = MODE_CLEAR;
  logic [AMT_W-1:0] amount = '0;
  logic busy;
  logic done;
  logic [1:0] status;
  logic [AMT_W-1:0] matched_value;
  logic [TOTAL_W-1:0] match_total;
  logic [POOL_FILL_W-1:0] pool_fill;

  best_fit_pool_matcher i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .amount        (amount),
    .done          (done),
    .status        (status),
    .matched_value (matched_value),
    .match_total   (match_total),
    .pool_fill     (pool_fill)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction: the pool is a queue kept in ascending order, like the cell chain
  // ---------------------------------------------------------------------------
  logic [AMT_W-1:0] pool_held[$];
  int unsigned      matches_since_clear = 0;

  // bookkeeping for the closing summary
  int unsigned n_accepted = 0;
  int unsigned n_matched = 0;
  int unsigned n_missed = 0;
  int unsigned n_dropped = 0;
  int unsigned n_cleared = 0;
  int unsigned peak_fill = 0;
  int unsigned peak_total = 0;

  function automatic pool_result_t predict_pool_step(logic [1:0] op, logic [AMT_W-1:0] amt);
    pool_result_t r;
    int pos;
    r.status  = STAT_OK;
    r.matched = '0;
    case (op)
      MODE_CLEAR: begin
        pool_held.delete();
        matches_since_clear = 0;
        n_cleared++;
      end
      MODE_ADD: begin
        if (pool_held.size() >= POOL_DEPTH) begin
          // full pool: value is dropped, nothing moves
          r.status = STAT_FULL;
          n_dropped++;
        end else begin
          // new value goes after any equal ones
          pos = 0;
          while (pos < pool_held.size() && pool_held[pos] <= amt) pos++;
          pool_held.insert(pos, amt);
        end
      end
      MODE_REQUEST: begin
        // best fit: first held value not below the demand
        pos = 0;
        while (pos < pool_held.size() && pool_held[pos] < amt) pos++;
        if (pos >= pool_held.size()) begin
          r.status = STAT_MISS;
          n_missed++;
        end else begin
          r.matched = pool_held[pos];
          pool_held.delete(pos);
          if (matches_since_clear < TOTAL_MAX) matches_since_clear++;
          n_matched++;
        end
      end
      default: begin
      end
    endcase
    r.total = matches_since_clear[TOTAL_W-1:0];
    r.fill  = POOL_FILL_W'(pool_held.size());
    if (pool_held.size() > peak_fill) peak_fill = pool_held.size();
    if (matches_since_clear > peak_total) peak_total = matches_since_clear;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: takes items off the pending queue, holds start until the item is
  // taken, then idles for the gap that came with the item
  // ---------------------------------------------------------------------------
  pool_item_t   pending_items[$];
  pool_result_t expected_results[$];
  int unsigned  idle_left = 0;

  always @(posedge clk) begin : drive_items
    pool_item_t nxt;
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      // the values on the ports right now are the ones the block sees at this edge
      if (start && !busy) begin
        expected_results.push_back(predict_pool_step(mode, amount));
        n_accepted++;
      end
      if (start && busy) begin
        // item not taken yet, keep it on the ports
      end else if (idle_left > 0) begin
        start <= 1'b0;
        idle_left--;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        mode   <= nxt.mode;
        amount <= nxt.amount;
        start  <= 1'b1;
        idle_left = nxt.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: done can't be held off, so every strobed cycle is a result
  // ---------------------------------------------------------------------------
  int unsigned n_errors = 0;

  task automatic check_field(string fname, logic [AMT_W-1:0] want, logic [AMT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $realtime, fname, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    pool_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d value %0d total %0d fill %0d",
                 $realtime, status, matched_value, match_total, pool_fill);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", AMT_W'(want.status), AMT_W'(status));
        check_field("matched_value", want.matched, matched_value);
        check_field("match_total", AMT_W'(want.total), AMT_W'(match_total));
        check_field("pool_fill", AMT_W'(want.fill), AMT_W'(pool_fill));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic [1:0] op, logic [AMT_W-1:0] amt, bit quiet);
    pool_item_t it;
    it.mode   = op;
    it.amount = amt;
    it.gap    = quiet ? 0 : $urandom_range(0, MAX_GAP);
    pending_items.push_back(it);
  endtask

  // mostly a narrow range so equal values and near misses are common,
  // with full-width values and the extremes mixed in
  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return AMT_MAX;
      2, 3:    return AMT_W'($urandom() & AMT_MAX);
      4:       return AMT_W'(AMT_MAX - $urandom_range(0, 15));
      default: return AMT_W'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned queued;
    int unsigned n;
    int unsigned seg;
    bit quiet;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part: extremes, each mode, equal values, zero demand, misses
    queue_item(MODE_CLEAR, '0, 0);
    queue_item(MODE_REQUEST, 31'd5, 0);         // request on an empty pool
    queue_item(MODE_ADD, '0, 0);
    queue_item(MODE_ADD, AMT_MAX, 0);
    queue_item(MODE_ADD, 31'd100, 0);
    queue_item(MODE_ADD, 31'd100, 0);           // equal value lands after the first
    queue_item(MODE_ADD, 31'd50, 1);
    queue_item(MODE_REQUEST, '0, 1);            // zero demand takes the smallest
    queue_item(MODE_REQUEST, 31'd100, 0);
    queue_item(MODE_REQUEST, 31'd101, 0);       // only the top value fits
    queue_item(MODE_REQUEST, 31'd101, 0);       // nothing fits now
    queue_item(MODE_REQUEST, AMT_MAX, 0);
    queue_item(MODE_UNUSED, AMT_MAX, 0);        // unused mode, state untouched
    queue_item(MODE_ADD, AMT_MAX, 1);
    queue_item(MODE_REQUEST, AMT_MAX, 1);       // largest demand, exact fit
    queue_item(MODE_ADD, 31'h2AAA_AAAA, 0);
    queue_item(MODE_ADD, 31'h5555_5555, 0);
    queue_item(MODE_REQUEST, 31'h2AAA_AAAB, 0);
    queue_item(MODE_UNUSED, '0, 0);
    queue_item(MODE_CLEAR, AMT_MAX, 0);
    queue_item(MODE_REQUEST, '0, 0);            // miss right after a clear

    // random part: bursts of adds push the pool past full, bursts of requests
    // drain it; some segments run with no idling at all
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      seg = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 3) == 0);
      case (seg)
        0, 1, 2: begin
          n = $urandom_range(20, 80);
          repeat (n) queue_item(MODE_ADD, pick_amount(), quiet);
          queued += n;
        end
        3, 4, 5: begin
          n = $urandom_range(10, 70);
          repeat (n) queue_item(MODE_REQUEST, pick_amount(), quiet);
          queued += n;
        end
        6, 7: begin
          n = $urandom_range(10, 40);
          repeat (n) begin
            case ($urandom_range(0, 19))
              0:       queue_item(MODE_CLEAR, pick_amount(), quiet);
              1:       queue_item(MODE_UNUSED, pick_amount(), quiet);
              2, 3, 4,
              5, 6, 7,
              8, 9:    queue_item(MODE_ADD, pick_amount(), quiet);
              default: queue_item(MODE_REQUEST, pick_amount(), quiet);
            endcase
          end
          queued += n;
        end
        8: begin
          queue_item(MODE_CLEAR, pick_amount(), quiet);
          queued++;
        end
        default: begin
          // noise: unused mode with any amount, not counted
          repeat ($urandom_range(1, 4))
            queue_item(MODE_UNUSED, AMT_W'($urandom() & AMT_MAX), quiet);
        end
      endcase
    end

    // closing items: a clear, a miss, an exact match, then a clear and one more miss
    queue_item(MODE_CLEAR, '0, 0);
    queue_item(MODE_REQUEST, '0, 0);
    queue_item(MODE_ADD, 31'd7, 0);
    queue_item(MODE_REQUEST, 31'd7, 0);
    queue_item(MODE_CLEAR, '0, 0);
    queue_item(MODE_REQUEST, '0, 0);

    // drain: everything sent, everything answered, then a few spare cycles
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, expected_results.size());
      n_errors++;
    end

    $display("run covered %0d items: %0d matched, %0d missed, %0d adds dropped, %0d clears",
             n_accepted, n_matched, n_missed, n_dropped, n_cleared);
    $display("pool fill peaked at %0d of %0d, match count reached %0d",
             peak_fill, POOL_DEPTH, peak_total);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("%0t: timeout with %0d items pending and %0d results outstanding",
             $realtime, pending_items.size(), expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
src/bfpm_pkg.sv
src/bfpm_cell.sv
src/best_fit_pool_matcher.sv
dv/best_fit_pool_matcher_tb.sv
